// File: design/wrc_pkg.sv
package wrc_pkg;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_RIFF    = 2'd1;
    localparam logic [1:0] ERR_WAVE    = 2'd2;
    localparam logic [1:0] ERR_NO_DATA = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int OUT_DATA_W = 16;

    // compact queue entry: value holds the payload byte, or the error code in its low bits
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_entry;

endpackage

// File: design/wrc_front.sv
module wrc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output wrc_pkg::t_entry   o_entry
);
    import wrc_pkg::*;

    localparam logic [2:0] PH_RIFF    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_WAVE    = 3'd2;
    localparam logic [2:0] PH_ID      = 3'd3;
    localparam logic [2:0] PH_SIZE    = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_IDLE    = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_rem, n_rem;
    logic        r_is_data, n_is_data;

    logic        w_accept;
    logic        w_done;
    logic [31:0] w_shift_be;
    logic [31:0] w_shift_le;
    logic [31:0] w_tag;

    assign o_ready    = !i_full;
    assign w_accept   = i_valid && !i_full;
    assign w_done     = (r_idx == 2'd3);
    assign w_shift_be = {r_shift[23:0], i_byte};
    assign w_shift_le = r_shift | ({24'd0, i_byte} << {r_idx, 3'b000});
    assign w_tag      = (r_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE;

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_is_data = r_is_data;
        o_push    = 1'b0;
        o_entry   = '0;
        case (r_phase)
            PH_RIFF, PH_WAVE: begin
                n_shift = w_shift_be;
                n_idx   = r_idx + 2'd1;
                if (w_done) begin
                    n_shift = '0;
                    if (w_shift_be != w_tag) begin
                        o_push        = 1'b1;
                        o_entry.kind  = KIND_ERROR;
                        o_entry.value = {6'd0, (r_phase == PH_RIFF) ? ERR_RIFF : ERR_WAVE};
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = (r_phase == PH_RIFF) ? PH_LENGTH : PH_ID;
                    end
                end
            end
            PH_LENGTH: begin
                n_idx = r_idx + 2'd1;
                if (w_done) begin
                    n_phase = PH_WAVE;
                end
            end
            PH_ID: begin
                n_shift = w_shift_be;
                n_idx   = r_idx + 2'd1;
                if (w_done) begin
                    n_is_data = (w_shift_be == TAG_DATA);
                    n_shift   = '0;
                    n_phase   = PH_SIZE;
                end
            end
            PH_SIZE: begin
                n_shift = w_shift_le;
                n_idx   = r_idx + 2'd1;
                if (w_done) begin
                    n_rem   = w_shift_le;
                    n_shift = '0;
                    if (r_is_data) begin
                        n_phase = (w_shift_le != '0) ? PH_PAYLOAD : PH_IDLE;
                    end else begin
                        n_phase = (w_shift_le != '0) ? PH_SKIP : PH_ID;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    n_phase = PH_ID;
                end
            end
            PH_PAYLOAD: begin
                n_rem         = r_rem - 32'd1;
                o_push        = 1'b1;
                o_entry.kind  = KIND_PAYLOAD;
                o_entry.value = i_byte;
                o_entry.last  = (r_rem == 32'd1) || i_eof;
                if (r_rem == 32'd1) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        // end of file: report a missing payload, then return to the start
        if (i_eof) begin
            if (!o_push && (r_phase < PH_PAYLOAD)) begin
                o_push        = 1'b1;
                o_entry.kind  = KIND_ERROR;
                o_entry.value = {6'd0, ERR_NO_DATA};
                o_entry.last  = 1'b0;
            end
            n_phase   = PH_RIFF;
            n_idx     = '0;
            n_shift   = '0;
            n_rem     = '0;
            n_is_data = 1'b0;
        end

        if (!w_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RIFF;
            r_idx     <= '0;
            r_shift   <= '0;
            r_rem     <= '0;
            r_is_data <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_shift   <= n_shift;
            r_rem     <= n_rem;
            r_is_data <= n_is_data;
        end
    end

    a_last_ends_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.kind == KIND_PAYLOAD && o_entry.last && !i_eof)
            |=> (r_phase == PH_IDLE))
        else $error("payload end did not move the parser to idle");

endmodule

// File: design/wrc_queue.sv
module wrc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wrc_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output wrc_pkg::t_entry   o_entry,
    output logic              o_full,
    output logic              o_empty
);
    import wrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("word popped from an empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue fill count lost a pushed word");

endmodule

// File: design/wrc_back.sv
module wrc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  wrc_pkg::t_entry                i_entry,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [wrc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast,
    output logic                           o_m_tuser
);
    import wrc_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_last;
    logic                  r_kind;
    logic                  w_load;
    logic [OUT_DATA_W-1:0] w_data;

    assign w_load = !r_valid || i_m_tready;
    assign o_pop  = w_load && !i_empty;

    // expand: error words carry the code above a zero byte
    assign w_data = (i_entry.kind == KIND_ERROR)
                  ? {6'd0, i_entry.value[1:0], 8'd0}
                  : {6'd0, ERR_NONE, i_entry.value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= w_data;
            r_last <= i_entry.last && (i_entry.kind == KIND_PAYLOAD);
            r_kind <= i_entry.kind;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_kind;

endmodule

// File: design/wav_riff_chunk_extractor_core.sv
// Channel  Dir  tdata                                   tlast         tuser
// s        in   [7:0] file_byte                         end_of_file   -
// m        out  [7:0] payload_byte, [9:8] error_code    last_payload  result_kind
//
// One file byte is taken per clock while o_s_tready is high; each byte yields zero or one result word.
// The parser takes a byte every cycle while the result queue has room; a result
// is written to the queue at the edge that accepts its byte and is loaded into
// the output register at the next edge at the earliest.
// Reset (i_rst_n low at a clock edge) returns the parser to the RIFF tag and
// empties the queue and the output register.
// A stalled output fills the queue of QUEUE_DEPTH words, then o_s_tready drops.
module wav_riff_chunk_extractor_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] file_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] payload_byte, [9:8] error_code
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] result_kind
);
    import wrc_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_push_entry;
    t_entry w_head_entry;

    wrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_eof   (i_s_tlast),
        .i_full  (w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    wrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    wrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_entry    (w_head_entry),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: sim/wrc_checker.sv
`timescale 1ns / 100ps

module wrc_checker
    import wrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] file_byte
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] payload_byte, [9:8] error_code
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,   // [0] result_kind
    output int          o_error_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        ST_RIFF_TAG,
        ST_FILE_LEN,
        ST_WAVE_TAG,
        ST_CHUNK_ID,
        ST_CHUNK_SIZE,
        ST_SKIP_BODY,
        ST_PAYLOAD,
        ST_DRAIN
    } parse_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic       last;
        logic [1:0] code;
    } parsed_word_t;

    parse_state_t  parse_state;
    logic [1:0]    byte_pos;
    logic [31:0]   field_acc;
    logic [31:0]   body_left;
    logic          id_is_data;
    parsed_word_t  pending_words[$];
    int            error_count;

    assign o_error_count = error_count;
    assign o_pending     = pending_words.size();

    task automatic clear_parser();
        parse_state = ST_RIFF_TAG;
        byte_pos    = 2'd0;
        field_acc   = 32'd0;
        body_left   = 32'd0;
        id_is_data  = 1'b0;
    endtask

    task automatic parse_file_byte(input logic [7:0] b, input logic eof);
        parse_state_t prev_state;
        logic         field_end;
        logic         produced;
        logic [31:0]  want_tag;
        parsed_word_t w;
        prev_state = parse_state;
        produced   = 1'b0;
        field_end  = (byte_pos == 2'd3);
        w          = '0;
        case (parse_state)
            ST_RIFF_TAG, ST_WAVE_TAG: begin
                field_acc = {field_acc[23:0], b};
                byte_pos  = byte_pos + 2'd1;
                if (field_end) begin
                    want_tag = (parse_state == ST_RIFF_TAG) ? TAG_RIFF : TAG_WAVE;
                    if (field_acc != want_tag) begin
                        w.kind   = KIND_ERROR;
                        w.code   = (parse_state == ST_RIFF_TAG) ? ERR_RIFF : ERR_WAVE;
                        produced = 1'b1;
                        parse_state = ST_DRAIN;
                    end else begin
                        parse_state = (parse_state == ST_RIFF_TAG) ? ST_FILE_LEN
                                                                   : ST_CHUNK_ID;
                    end
                    field_acc = 32'd0;
                end
            end
            ST_FILE_LEN: begin
                byte_pos = byte_pos + 2'd1;
                if (field_end)
                    parse_state = ST_WAVE_TAG;
            end
            ST_CHUNK_ID: begin
                field_acc = {field_acc[23:0], b};
                byte_pos  = byte_pos + 2'd1;
                if (field_end) begin
                    id_is_data  = (field_acc == TAG_DATA);
                    field_acc   = 32'd0;
                    parse_state = ST_CHUNK_SIZE;
                end
            end
            ST_CHUNK_SIZE: begin
                // size arrives little-endian
                field_acc = field_acc | (32'(b) << (8 * byte_pos));
                byte_pos  = byte_pos + 2'd1;
                if (field_end) begin
                    body_left = field_acc;
                    field_acc = 32'd0;
                    if (id_is_data)
                        parse_state = (body_left != 0) ? ST_PAYLOAD : ST_DRAIN;
                    else
                        parse_state = (body_left != 0) ? ST_SKIP_BODY : ST_CHUNK_ID;
                end
            end
            ST_SKIP_BODY: begin
                body_left = body_left - 32'd1;
                if (body_left == 0)
                    parse_state = ST_CHUNK_ID;
            end
            ST_PAYLOAD: begin
                body_left = body_left - 32'd1;
                w.kind    = KIND_PAYLOAD;
                w.payload = b;
                w.last    = (body_left == 0) || eof;
                w.code    = ERR_NONE;
                produced  = 1'b1;
                if (body_left == 0)
                    parse_state = ST_DRAIN;
            end
            default: ;
        endcase

        // end of file before any payload word reports a missing data chunk
        if (eof) begin
            if (!produced && prev_state != ST_PAYLOAD && prev_state != ST_DRAIN) begin
                w        = '0;
                w.kind   = KIND_ERROR;
                w.code   = ERR_NO_DATA;
                produced = 1'b1;
            end
            clear_parser();
        end
        if (produced)
            pending_words.push_back(w);
    endtask

    task automatic compare_word();
        parsed_word_t w;
        if (pending_words.size() == 0) begin
            $error("unexpected output word: tuser=%0d tdata=0x%04h tlast=%0d",
                   i_m_tuser, i_m_tdata, i_m_tlast);
            error_count++;
        end else begin
            w = pending_words.pop_front();
            if (i_m_tuser !== w.kind) begin
                $error("result_kind: expected %0d, got %0d", w.kind, i_m_tuser);
                error_count++;
            end
            if (i_m_tdata[7:0] !== w.payload) begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", w.payload, i_m_tdata[7:0]);
                error_count++;
            end
            if (i_m_tdata[9:8] !== w.code) begin
                $error("error_code: expected %0d, got %0d", w.code, i_m_tdata[9:8]);
                error_count++;
            end
            if (i_m_tlast !== w.last) begin
                $error("last_payload: expected %0d, got %0d", w.last, i_m_tlast);
                error_count++;
            end
            if (i_m_tdata[15:10] !== 6'd0) begin
                $error("tdata pad: expected 0x00, got 0x%02h", i_m_tdata[15:10]);
                error_count++;
            end
        end
    endtask

    initial begin
        error_count = 0;
        clear_parser();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                compare_word();
            if (i_s_tvalid && i_s_tready)
                parse_file_byte(i_s_tdata, i_s_tlast);
        end
    end

endmodule

// File: sim/tb_wav_riff_chunk_extractor_core.sv
`timescale 1ns / 100ps

module tb_wav_riff_chunk_extractor_core;
    import wrc_pkg::*;

    localparam int RANDOM_BYTES = 1050;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [31:0] TAG_DISP = 32'h4449_5350;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    int          error_count;
    int          pending;
    int          cycles = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_run  = 0;
    logic [7:0]  file_bytes[$];

    // period is 4 ns: invert every 2 ns
    always #2 i_clk = ~i_clk;

    wav_riff_chunk_extractor_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    wrc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .i_m_tuser     (o_m_tuser),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: runs of always-ready, random and mostly-stalled
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(8, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_word(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eof;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // tags go out big-endian, sizes little-endian
    task automatic push_tag(input logic [31:0] tag);
        int i;
        for (i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8*i +: 8]);
    endtask

    task automatic push_le32(input logic [31:0] v);
        int i;
        for (i = 0; i < 4; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic push_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic build_good_file(output int useful);
        int          n_chunks;
        int          k;
        int          trailing;
        int          cut;
        logic [31:0] id;
        logic [31:0] size;
        file_bytes.delete();
        trailing = 0;
        push_tag(TAG_RIFF);
        push_le32($urandom);
        push_tag(TAG_WAVE);
        n_chunks = $urandom_range(0, 3);
        for (k = 0; k < n_chunks; k++) begin
            case ($urandom_range(0, 3))
                0: id = TAG_DISP;
                1: id = TAG_FMT;
                2: id = TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
                default: id = $urandom;
            endcase
            if (id == TAG_DATA)
                id = TAG_FMT;
            size = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 6);
            push_tag(id);
            push_le32(size);
            push_random(size);
        end
        push_tag(TAG_DATA);
        if ($urandom_range(0, 11) == 0) begin
            // huge size: the end flag cuts the payload short
            size = $urandom | 32'h100;
            push_le32(size);
            push_random($urandom_range(1, 10));
        end else begin
            size = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom_range(1, 12);
            push_le32(size);
            push_random(size);
            trailing = $urandom_range(0, 3);
            push_random(trailing);
        end
        useful = file_bytes.size() - trailing;
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
            if (useful > cut)
                useful = cut;
        end
    endtask

    task automatic build_broken_file(output int useful);
        int pos;
        file_bytes.delete();
        push_tag(TAG_RIFF);
        push_le32($urandom);
        push_tag(TAG_WAVE);
        // corrupt one bit of one tag byte
        pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 11);
        file_bytes[pos] = file_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
        useful = (pos < 4) ? 4 : 12;
        while (file_bytes.size() > useful)
            void'(file_bytes.pop_back());
        push_random($urandom_range(0, 5));
    endtask

    initial begin
        int sent;
        int useful;
        int pick;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // end flag on the very first byte
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        send_file();

        // bad RIFF tag whose last byte also carries the end flag
        file_bytes.delete();
        push_tag({TAG_RIFF[31:8], 8'hFF});
        send_file();

        // minimal file, payload at both byte extremes, end flag on the last one
        file_bytes.delete();
        push_tag(TAG_RIFF);
        push_le32(32'hFFFF_FFFF);
        push_tag(TAG_WAVE);
        push_tag(TAG_DATA);
        push_le32(32'd2);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        send_file();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
                build_good_file(useful);
            end else if (pick < 19) begin
                build_broken_file(useful);
            end else begin
                file_bytes.delete();
                push_random($urandom_range(1, 10));
                useful = file_bytes.size();
            end
            send_file();
            sent += useful;
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: wav_riff_chunk_extractor_core.f
design/wrc_pkg.sv
design/wrc_front.sv
design/wrc_queue.sv
design/wrc_back.sv
design/wav_riff_chunk_extractor_core.sv
sim/wrc_checker.sv
sim/tb_wav_riff_chunk_extractor_core.sv
